>>> design/sqd_pkg.sv
// Package for the SLIP quaternion deframer: SLIP codes, frame geometry,
// the command passed from front to back, and the result layout.
// No dependencies.
package sqd_pkg;

   localparam logic [7:0] SLIP_END     = 8'hC0;
   localparam logic [7:0] SLIP_ESC     = 8'hDB;
   localparam logic [7:0] SLIP_ESC_END = 8'hDC;
   localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;

   localparam int FRAME_LEN = 17;
   localparam int COUNT_W   = 5;
   localparam int WORD_W    = 32;

   localparam int          CSR_ADDR_W        = 2;
   localparam int          CSR_DATA_W        = 32;
   localparam logic [CSR_ADDR_W-1:0] ADDR_ACCEPTED_TYPE = 2'd0;

   typedef struct packed {
      logic       is_end;
      logic [7:0] data;
   } cmd_type;

   typedef struct packed {
      logic [WORD_W-1:0] word_0;
      logic [WORD_W-1:0] word_1;
      logic [WORD_W-1:0] word_2;
      logic [WORD_W-1:0] word_3;
   } quat_result_type;

endpackage

>>> design/sqd_fifo.sv
// Small register-based queue used between front and back and on the result side.
// Depends on nothing but its parameters.
module sqd_fifo #(
   parameter int WIDTH = 9,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> design/sqd_front.sv
// Front end: accepts raw bytes, tracks the SLIP escape, emits store/end commands.
// Depends on sqd_pkg.
module sqd_front
   import sqd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic [7:0] req_rx_byte,
   output logic       req_full,
   output logic       cmd_push,
   output cmd_type    cmd_data,
   input  logic       cmd_full
);

   logic escape_ff, escape_in;
   logic accept;

   assign req_full = cmd_full;
   assign accept   = req_push && !cmd_full;
   // an escape byte only arms the flag; everything else becomes a command
   assign cmd_push = accept && (req_rx_byte != SLIP_ESC);

   always_comb begin
      cmd_data.is_end = 1'b0;
      cmd_data.data   = req_rx_byte;
      case (req_rx_byte)
         SLIP_END: begin
            cmd_data.is_end = 1'b1;
         end
         SLIP_ESC_END: begin
            cmd_data.data = escape_ff ? SLIP_END : SLIP_ESC_END;
         end
         SLIP_ESC_ESC: begin
            cmd_data.data = escape_ff ? SLIP_ESC : SLIP_ESC_ESC;
         end
         default: begin
            cmd_data.data = req_rx_byte;
         end
      endcase
   end

   assign escape_in = accept ? (req_rx_byte == SLIP_ESC) : escape_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         escape_ff <= 1'b0;
      end else begin
         escape_ff <= escape_in;
      end
   end

endmodule

>>> design/sqd_back.sv
// Back end: builds the 17-byte frame from commands and checks it at frame end.
// Depends on sqd_pkg.
module sqd_back
   import sqd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic [7:0]      accepted_type,
   input  logic            cmd_empty,
   input  cmd_type         cmd_data,
   output logic            cmd_pop,
   input  logic            rsp_full,
   output logic            rsp_push,
   output quat_result_type rsp_data
);

   logic [7:0]         frame_ff [FRAME_LEN];
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               frame_done;

   // hold an end command while the result queue has no room
   assign cmd_pop    = !cmd_empty && (!cmd_data.is_end || !rsp_full);
   assign frame_done = (count_ff == COUNT_W'(FRAME_LEN)) && (frame_ff[0] == accepted_type);
   assign rsp_push   = cmd_pop && cmd_data.is_end && frame_done;

   assign rsp_data.word_0 = {frame_ff[1],  frame_ff[2],  frame_ff[3],  frame_ff[4]};
   assign rsp_data.word_1 = {frame_ff[5],  frame_ff[6],  frame_ff[7],  frame_ff[8]};
   assign rsp_data.word_2 = {frame_ff[9],  frame_ff[10], frame_ff[11], frame_ff[12]};
   assign rsp_data.word_3 = {frame_ff[13], frame_ff[14], frame_ff[15], frame_ff[16]};

   always_comb begin
      count_in = count_ff;
      if (cmd_pop) begin
         if (cmd_data.is_end) begin
            count_in = '0;
         end else if (count_ff < COUNT_W'(FRAME_LEN)) begin
            count_in = count_ff + COUNT_W'(1);
         end else begin
            count_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop && !cmd_data.is_end && (count_ff < COUNT_W'(FRAME_LEN))) begin
         frame_ff[count_ff] <= cmd_data.data;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(FRAME_LEN))
      else $error("byte count beyond frame length");

   a_emit_on_end : assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> (cmd_pop && cmd_data.is_end && count_ff == COUNT_W'(FRAME_LEN)))
      else $error("result pushed without a complete frame end");

   a_overflow_restart : assert property (@(posedge clock) disable iff (reset)
      (cmd_pop && !cmd_data.is_end && count_ff == COUNT_W'(FRAME_LEN)) |=> (count_ff == '0))
      else $error("overlong frame did not restart its count");

   a_no_push_full : assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full)
      else $error("result pushed into a full queue");
`endif

endmodule

>>> design/slip_quaternion_packet_deframer_unit.sv
// Top level of the SLIP quaternion packet deframer.
// Depends on sqd_pkg, sqd_fifo, sqd_front and sqd_back.
//
// Strips SLIP byte stuffing from a received byte stream, one byte per
// transaction on the req_ side, and returns one transaction on the rsp_ side
// for every frame that ends (0xC0) holding exactly 17 bytes whose first byte
// matches the accepted_type register: four big-endian 32-bit words taken from
// frame bytes 1..16. Short and wrong-type frames produce nothing; a frame
// growing past 17 bytes restarts its count and its later bytes form a new
// frame. Throughput is one byte per clock while the command queue has room:
// the front end decodes the escape in the accept cycle and the back end
// consumes one command per cycle; a result enters the result queue when the
// back end takes the end byte. A command queue of CMD_QUEUE_DEPTH entries
// separates the two halves; the result queue holds RSP_QUEUE_DEPTH results,
// and an end byte waits in the command queue while that queue is full.
// accepted_type lies at byte address 0 of the csr_ port and resets to 0.
module slip_quaternion_packet_deframer_unit
   import sqd_pkg::*;
#(
   parameter int CMD_QUEUE_DEPTH = 2,
   parameter int RSP_QUEUE_DEPTH = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   // byte input
   input  logic                  req_push,
   input  logic [7:0]            req_rx_byte,
   output logic                  req_full,
   // result output
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [WORD_W-1:0]     rsp_quat_word_0,
   output logic [WORD_W-1:0]     rsp_quat_word_1,
   output logic [WORD_W-1:0]     rsp_quat_word_2,
   output logic [WORD_W-1:0]     rsp_quat_word_3,
   // configuration
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [7:0]      accepted_type_ff, accepted_type_in;
   logic            csr_write;

   logic            cmd_push, cmd_full, cmd_pop, cmd_empty;
   cmd_type         cmd_push_data, cmd_pop_data;

   logic            res_push, res_full;
   quat_result_type res_push_data, res_pop_data;

   // Configuration: zero wait states; ignore writes to unmapped addresses.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign accepted_type_in = (csr_write && csr_paddr == ADDR_ACCEPTED_TYPE)
                             ? csr_pwdata[7:0] : accepted_type_ff;
   assign csr_prdata = (csr_paddr == ADDR_ACCEPTED_TYPE)
                       ? {{(CSR_DATA_W - 8){1'b0}}, accepted_type_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         accepted_type_ff <= '0;
      end else begin
         accepted_type_ff <= accepted_type_in;
      end
   end

   // Front end: decode escapes, drop escape bytes, push commands.
   sqd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_rx_byte (req_rx_byte),
      .req_full    (req_full),
      .cmd_push    (cmd_push),
      .cmd_data    (cmd_push_data),
      .cmd_full    (cmd_full)
   );

   // Decouple decode from frame assembly.
   sqd_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (CMD_QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_push_data),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_pop_data),
      .empty     (cmd_empty)
   );

   // Back end: assemble the frame and qualify it at the end byte.
   sqd_back u_back (
      .clock         (clock),
      .reset         (reset),
      .accepted_type (accepted_type_ff),
      .cmd_empty     (cmd_empty),
      .cmd_data      (cmd_pop_data),
      .cmd_pop       (cmd_pop),
      .rsp_full      (res_full),
      .rsp_push      (res_push),
      .rsp_data      (res_push_data)
   );

   // Hold finished results until the consumer pops them.
   sqd_fifo #(
      .WIDTH ($bits(quat_result_type)),
      .DEPTH (RSP_QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_push_data),
      .full      (res_full),
      .pop       (rsp_pop),
      .pop_data  (res_pop_data),
      .empty     (rsp_empty)
   );

   assign rsp_quat_word_0 = res_pop_data.word_0;
   assign rsp_quat_word_1 = res_pop_data.word_1;
   assign rsp_quat_word_2 = res_pop_data.word_2;
   assign rsp_quat_word_3 = res_pop_data.word_3;

endmodule
